[rtl/lkd_pkg.sv]
`default_nettype none
package lkd_pkg;

    typedef enum logic [1:0] {
        MODE_TICK    = 2'd0,
        MODE_DIGIT   = 2'd1,
        MODE_DISPLAY = 2'd2,
        MODE_READKEY = 2'd3
    } t_mode;

    localparam logic [7:0] CMD_DISPLAY      = 8'h48;
    localparam logic [7:0] CMD_READKEY      = 8'h49;
    localparam logic [7:0] DIGIT_BASE       = 8'h68;
    localparam logic [7:0] KEY_BASE         = 8'h44;
    localparam logic [7:0] KEY_LAST         = 8'h77;
    localparam logic [7:0] UNIT_TICKS_RESET = 8'd1;

endpackage
`default_nettype wire

[rtl/lkd_if.sv]
`default_nettype none
interface lkd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [1:0] digit;
    logic [7:0] data_byte;
    logic       sda_in;

    modport source (output valid, mode, digit, data_byte, sda_in, input ready);
    modport sink   (input valid, mode, digit, data_byte, sda_in, output ready);
endinterface

interface lkd_out_if;
    logic       valid;
    logic       ready;
    logic       scl;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic       key_valid;
    logic [7:0] key_raw;
    logic [6:0] key_code;

    modport source (output valid, scl, sda_release, busy_res, done_res, key_valid,
                    key_raw, key_code, input ready);
    modport sink   (input valid, scl, sda_release, busy_res, done_res, key_valid,
                    key_raw, key_code, output ready);
endinterface

interface lkd_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/led_key_driver_two_wire_master.sv]
// Channel  Dir  Payload                                                    Accept
// i_in     in   mode, digit, data_byte, sda_in                             valid & ready
// o_out    out  scl, sda_release, busy_res, done_res, key_valid,           valid & ready
//               key_raw, key_code
// i_cfg    in   data (unit_ticks)                                          valid & ready
//
// One item per clock unless the output stalls; each item is one tick, its result registered.
// The input is taken whenever the output register is empty or being drained.
// A stalled output holds its item and stalls the input; no item is dropped.
// i_rst_n is synchronous, active low; the sequencer returns to idle with both lines released.
// i_cfg is always ready and sets unit_ticks (reset 1, zero acts as one).
`default_nettype none
module led_key_driver_two_wire_master
    import lkd_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lkd_in_if.sink    i_in,
    lkd_out_if.source o_out,
    lkd_cfg_if.sink   i_cfg
);

    logic [7:0] r_unit_ticks;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unit_ticks <= UNIT_TICKS_RESET;
        end else if (i_cfg.valid) begin
            r_unit_ticks <= i_cfg.data;
        end
    end

    lkd_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_unit_ticks (r_unit_ticks),
        .i_in         (i_in),
        .o_out        (o_out)
    );

endmodule
`default_nettype wire

[rtl/lkd_keymap.sv]
`default_nettype none
module lkd_keymap
    import lkd_pkg::*;
(
    input  wire logic [7:0] i_key,
    output logic      [6:0] o_code
);

    logic [7:0] w_off;
    logic [6:0] w_row;
    logic       w_hit;

    assign w_off = i_key - KEY_BASE;
    assign w_row = {4'b0, w_off[5:3]};
    assign w_hit = (i_key >= KEY_BASE) && (i_key <= KEY_LAST) && !w_off[2];

    // row*10 + col + 11
    assign o_code = w_hit ? ((w_row << 3) + (w_row << 1) + 7'd11 + {5'b0, w_off[1:0]})
                          : 7'd0;

endmodule
`default_nettype wire

[rtl/lkd_seq.sv]
`default_nettype none
module lkd_seq
    import lkd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_unit_ticks,
    lkd_in_if.sink          i_in,
    lkd_out_if.source       o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_WBIT1,
        S_ACK1,
        S_WBIT2,
        S_RBIT,
        S_ACK2,
        S_STOP
    } t_state;

    t_state     r_state, n_state;
    logic [7:0] r_unit,  n_unit;
    logic [2:0] r_phase, n_phase;
    logic [3:0] r_bit,   n_bit;
    logic [7:0] r_shift, n_shift;
    logic [7:0] r_pend,  n_pend;
    logic [1:0] r_kind,  n_kind;
    logic       r_scl,   n_scl;
    logic       r_sda,   n_sda;

    logic       r_o_valid;
    logic       r_o_scl;
    logic       r_o_sda;
    logic       r_o_busy;
    logic       r_o_done;
    logic       r_o_kvalid;
    logic [7:0] r_o_raw;
    logic [6:0] r_o_code;

    logic       w_acc;
    logic       w_tick;
    logic       w_done;
    logic       w_kvalid;
    logic [7:0] w_ticks;
    logic [6:0] w_code;

    assign i_in.ready = !r_o_valid || o_out.ready;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_ticks    = (i_unit_ticks == 8'd0) ? 8'd1 : i_unit_ticks;
    assign w_tick     = ({1'b0, r_unit} + 9'd1) >= {1'b0, w_ticks};

    always_comb begin
        n_state = r_state;
        n_unit  = r_unit;
        n_phase = r_phase;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_pend  = r_pend;
        n_kind  = r_kind;
        n_scl   = r_scl;
        n_sda   = r_sda;
        w_done  = 1'b0;
        if (r_state == S_IDLE) begin
            if (i_in.mode != MODE_TICK) begin
                n_kind = i_in.mode;
                case (i_in.mode)
                    MODE_DIGIT:   n_shift = DIGIT_BASE + {5'b0, i_in.digit, 1'b0};
                    MODE_DISPLAY: n_shift = CMD_DISPLAY;
                    default:      n_shift = CMD_READKEY;
                endcase
                n_pend  = i_in.data_byte;
                n_state = S_START;
                n_phase = 3'd0;
                n_unit  = 8'd0;
                n_bit   = 4'd0;
                n_scl   = 1'b1;
                n_sda   = 1'b1;
            end
        end else if (!w_tick) begin
            n_unit = r_unit + 8'd1;
        end else begin
            n_unit = 8'd0;
            case (r_state)
                S_START: begin
                    if (r_phase < 3'd3) begin
                        n_phase = r_phase + 3'd1;
                        if (r_phase == 3'd1) n_sda = 1'b0;
                    end else begin
                        n_state = S_WBIT1;
                        n_phase = 3'd0;
                        n_bit   = 4'd0;
                        n_scl   = 1'b0;
                        n_sda   = r_shift[7];
                    end
                end
                S_WBIT1, S_WBIT2: begin
                    if (r_phase == 3'd0) begin
                        n_phase = 3'd1;
                        n_scl   = 1'b1;
                    end else if (r_phase == 3'd1) begin
                        n_phase = 3'd2;
                        n_scl   = 1'b0;
                    end else begin
                        n_shift = {r_shift[6:0], 1'b0};
                        n_bit   = r_bit + 4'd1;
                        n_phase = 3'd0;
                        if (!n_bit[3]) begin
                            n_scl = 1'b0;
                            n_sda = r_shift[6];
                        end else begin
                            n_state = (r_state == S_WBIT1) ? S_ACK1 : S_ACK2;
                            n_sda   = 1'b1;
                        end
                    end
                end
                S_ACK1, S_ACK2: begin
                    if (r_phase == 3'd0) begin
                        n_phase = 3'd1;
                        n_scl   = 1'b1;
                    end else if (r_phase == 3'd1) begin
                        n_phase = 3'd2;
                        n_scl   = 1'b0;
                    end else begin
                        n_phase = 3'd0;
                        n_bit   = 4'd0;
                        if (r_state == S_ACK2) begin
                            n_state = S_STOP;
                            n_scl   = 1'b0;
                            n_sda   = 1'b0;
                        end else if (r_kind == MODE_READKEY) begin
                            n_state = S_RBIT;
                            n_shift = 8'd0;
                            n_scl   = 1'b0;
                        end else begin
                            n_state = S_WBIT2;
                            n_shift = r_pend;
                            n_scl   = 1'b0;
                            n_sda   = r_pend[7];
                        end
                    end
                end
                S_RBIT: begin
                    if (r_phase < 3'd3) begin
                        n_phase = r_phase + 3'd1;
                        if (r_phase == 3'd1) begin
                            n_scl   = 1'b1;
                            n_shift = {r_shift[6:0], i_in.sda_in};
                        end
                    end else begin
                        n_bit   = r_bit + 4'd1;
                        n_phase = 3'd0;
                        if (!n_bit[3]) begin
                            n_scl = 1'b0;
                        end else begin
                            n_state = S_ACK2;
                            n_sda   = 1'b1;
                        end
                    end
                end
                S_STOP: begin
                    if (r_phase < 3'd3) begin
                        n_phase = r_phase + 3'd1;
                        if (r_phase == 3'd1) n_scl = 1'b1;
                    end else begin
                        n_sda   = 1'b1;
                        n_state = S_IDLE;
                        n_phase = 3'd0;
                        w_done  = 1'b1;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                    n_phase = 3'd0;
                    n_scl   = 1'b1;
                    n_sda   = 1'b1;
                end
            endcase
        end
    end

    assign w_kvalid = w_done && (r_kind == MODE_READKEY);

    lkd_keymap u_keymap (
        .i_key  (n_shift),
        .o_code (w_code)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_unit    <= 8'd0;
            r_phase   <= 3'd0;
            r_bit     <= 4'd0;
            r_shift   <= 8'd0;
            r_pend    <= 8'd0;
            r_kind    <= MODE_TICK;
            r_scl     <= 1'b1;
            r_sda     <= 1'b1;
            r_o_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_state    <= n_state;
                r_unit     <= n_unit;
                r_phase    <= n_phase;
                r_bit      <= n_bit;
                r_shift    <= n_shift;
                r_pend     <= n_pend;
                r_kind     <= n_kind;
                r_scl      <= n_scl;
                r_sda      <= n_sda;
                r_o_valid  <= 1'b1;
                r_o_scl    <= n_scl;
                r_o_sda    <= n_sda;
                r_o_busy   <= (n_state != S_IDLE);
                r_o_done   <= w_done;
                r_o_kvalid <= w_kvalid;
                r_o_raw    <= w_kvalid ? n_shift : 8'd0;
                r_o_code   <= w_kvalid ? w_code : 7'd0;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out.valid       = r_o_valid;
    assign o_out.scl         = r_o_scl;
    assign o_out.sda_release = r_o_sda;
    assign o_out.busy_res    = r_o_busy;
    assign o_out.done_res    = r_o_done;
    assign o_out.key_valid   = r_o_kvalid;
    assign o_out.key_raw     = r_o_raw;
    assign o_out.key_code    = r_o_code;

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_done) |-> !r_o_busy)
        else $error("done item still reports busy");

    a_key_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_kvalid) |-> r_o_done)
        else $error("key valid without done");

    a_code_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && (r_o_code != 7'd0)) |-> r_o_kvalid)
        else $error("key code without key valid");

    a_cmd_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && (r_state == S_IDLE) && (i_in.mode != MODE_TICK)) |=> (r_state == S_START))
        else $error("command did not start a transaction");

endmodule
`default_nettype wire
